FILE: rtl/dscb_pkg.sv
package dscb_pkg;

	localparam int EXP_ITER = 20;
	localparam int DIV_BITS = 49;
	localparam int REM_W = 31;
	localparam int IDX_W = 6;
	localparam int LATENCY = 1 + DIV_BITS + 3 + 2 + EXP_ITER + 5 + 7 + 3 * EXP_ITER + 3;

	localparam logic [31:0] LN2_Q32 = 32'd2977044472;
	localparam logic [62:0] E_CAP = 63'h4000_0000_0000_0000;
	localparam logic [38:0] D_CAP = 39'h7F_FFFF_FFFF;
	localparam logic [36:0] K_LIMIT = 37'd98242467576;
	localparam logic [32:0] ONE_Q32 = 33'h1_0000_0000;

	localparam logic [1:0] REGION_CORE = 2'd0;
	localparam logic [1:0] REGION_LOW = 2'd1;
	localparam logic [1:0] REGION_HIGH = 2'd2;

	localparam logic [2:0] REG_ALPHA_LOW = 3'd0;
	localparam logic [2:0] REG_ALPHA_HIGH = 3'd1;
	localparam logic [2:0] REG_POWER_LOW = 3'd2;
	localparam logic [2:0] REG_POWER_HIGH = 3'd3;
	localparam logic [2:0] REG_PEAK_MEAN = 3'd4;
	localparam logic [2:0] REG_PEAK_WIDTH = 3'd5;
	localparam logic [2:0] REG_NORM_SCALE = 3'd6;

	typedef struct packed {
		logic [DIV_BITS-1:0] num;
		logic [DIV_BITS-1:0] quo;
		logic [REM_W-1:0] rem;
		logic neg;
	} div_t;

	typedef struct packed {
		logic [1:0] region;
		logic [23:0] n;
		logic [46:0] aa_half;
		logic [62:0] e_core;
		logic [5:0] p_num;
		logic [5:0] p_den;
	} side_t;

	typedef struct packed {
		logic [1:0] region;
		logic zero;
		logic [5:0] k;
	} exps_t;

	function automatic logic [31:0] recip_q32(input logic [IDX_W-1:0] i);
		logic [31:0] r;
		case (i)
			6'd1: r = 32'd4294967295;
			6'd2: r = 32'd2147483648;
			6'd3: r = 32'd1431655765;
			6'd4: r = 32'd1073741824;
			6'd5: r = 32'd858993459;
			6'd6: r = 32'd715827882;
			6'd7: r = 32'd613566756;
			6'd8: r = 32'd536870912;
			6'd9: r = 32'd477218588;
			6'd10: r = 32'd429496729;
			6'd11: r = 32'd390451572;
			6'd12: r = 32'd357913941;
			6'd13: r = 32'd330382099;
			6'd14: r = 32'd306783378;
			6'd15: r = 32'd286331153;
			6'd16: r = 32'd268435456;
			6'd17: r = 32'd252645135;
			6'd18: r = 32'd238609294;
			6'd19: r = 32'd226050910;
			6'd20: r = 32'd214748364;
			6'd21: r = 32'd204522252;
			6'd22: r = 32'd195225786;
			6'd23: r = 32'd186737708;
			6'd24: r = 32'd178956970;
			6'd25: r = 32'd171798691;
			6'd26: r = 32'd165191049;
			6'd27: r = 32'd159072862;
			6'd28: r = 32'd153391689;
			6'd29: r = 32'd148102320;
			6'd30: r = 32'd143165576;
			6'd31: r = 32'd138547332;
			6'd32: r = 32'd134217728;
			6'd33: r = 32'd130150524;
			6'd34: r = 32'd126322567;
			6'd35: r = 32'd122713351;
			6'd36: r = 32'd119304647;
			6'd37: r = 32'd116080197;
			6'd38: r = 32'd113025455;
			6'd39: r = 32'd110127366;
			6'd40: r = 32'd107374182;
			default: r = 32'd0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/dscb_div_cell.sv
module dscb_div_cell import dscb_pkg::*; (
	input logic clk,
	input logic en,
	input logic [REM_W-1:0] divisor,
	input div_t d_in,
	output div_t d_out
);

	div_t d_q;
	logic [REM_W:0] trial;
	logic [REM_W:0] diff;
	logic ge;

	always_comb begin
		trial = {d_in.rem, d_in.num[DIV_BITS-1]};
		diff = trial - {1'b0, divisor};
		ge = trial >= {1'b0, divisor};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_q.num <= {d_in.num[DIV_BITS-2:0], 1'b0};
			d_q.quo <= {d_in.quo[DIV_BITS-2:0], ge};
			d_q.rem <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
			d_q.neg <= d_in.neg;
		end
	end

	assign d_out = d_q;

endmodule

FILE: rtl/dscb_log_cell.sv
module dscb_log_cell import dscb_pkg::*; (
	input logic clk,
	input logic en,
	input logic [31:0] m_in,
	input logic [EXP_ITER-1:0] frac_in,
	output logic [31:0] m_out,
	output logic [EXP_ITER-1:0] frac_out
);

	logic [63:0] sq;
	logic [32:0] sq_sh;
	logic [31:0] m_q;
	logic [EXP_ITER-1:0] frac_q;

	always_comb begin
		sq = 64'(m_in) * 64'(m_in);
		sq_sh = sq[63:31];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_q <= sq_sh[32] ? sq_sh[32:1] : sq_sh[31:0];
			frac_q <= {frac_in[EXP_ITER-2:0], sq_sh[32]};
		end
	end

	assign m_out = m_q;
	assign frac_out = frac_q;

endmodule

FILE: rtl/dscb_exp_cell.sv
module dscb_exp_cell import dscb_pkg::*; (
	input logic clk,
	input logic en,
	input logic [IDX_W-1:0] idx,
	input logic [32:0] p_in,
	input logic [31:0] r_in,
	output logic [32:0] p_out,
	output logic [31:0] r_out
);

	logic [63:0] prod;
	logic [31:0] v_s1, r_s1;
	logic [63:0] qprod;
	logic [31:0] q0_s2, v_s2, r_s2;
	logic [37:0] qi;
	logic [31:0] remd;
	logic [31:0] q;
	logic [32:0] p_s3;
	logic [31:0] r_s3;

	always_comb begin
		prod = 64'(r_in) * 64'(p_in[31:0]);
		qprod = 64'(v_s1) * 64'(recip_q32(idx));
		qi = 38'(q0_s2) * 38'(idx);
		remd = v_s2 - qi[31:0];
		q = (remd >= 32'(idx)) ? q0_s2 + 32'd1 : q0_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			v_s1 <= p_in[32] ? r_in : prod[63:32];
			r_s1 <= r_in;
			q0_s2 <= qprod[63:32];
			v_s2 <= v_s1;
			r_s2 <= r_s1;
			p_s3 <= ONE_Q32 - {1'b0, q};
			r_s3 <= r_s2;
		end
	end

	assign p_out = p_s3;
	assign r_out = r_s3;

endmodule

FILE: rtl/double_sided_crystal_ball_eval.sv
// Double-sided Crystal Ball shape evaluator.
// Input channel: in_valid/in_ready carry one abscissa x_position (signed Q16.16).
// Output channel: out_valid/out_ready carry shape_value (unsigned Q32.16,
// norm_scale times the shape) and region (core, low tail or high tail).
// Configuration: write cfg_data to register cfg_index while cfg_we is high;
// write only while no request is in flight. Indexes beyond the list are dropped.
// Throughput: one request per cycle while the receiver takes results. The
// pipeline is built from the 49-cell quotient chain for t, the EXP_ITER
// log cells and the EXP_ITER three-stage exponential cells.
// Reset clears all in-flight requests and loads the register defaults.
// When the receiver stalls, the whole pipeline holds and in_ready drops
// until the pending result is taken; no request is lost.
module double_sided_crystal_ball_eval import dscb_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [2:0] cfg_index,
	input logic [47:0] cfg_data,
	input logic in_valid,
	output logic in_ready,
	input logic signed [31:0] x_position,
	output logic out_valid,
	input logic out_ready,
	output logic [47:0] shape_value,
	output logic [1:0] region
);

	logic [23:0] alpha_low_q, alpha_high_q, power_low_q, power_high_q;
	logic [31:0] peak_mean_q;
	logic [30:0] peak_width_q;
	logic [47:0] norm_scale_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_low_q <= 24'd65536;
			alpha_high_q <= 24'd131072;
			power_low_q <= 24'd131072;
			power_high_q <= 24'd65536;
			peak_mean_q <= 32'd0;
			peak_width_q <= 31'd65536;
			norm_scale_q <= 48'd65536;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_ALPHA_LOW: alpha_low_q <= cfg_data[23:0];
				REG_ALPHA_HIGH: alpha_high_q <= cfg_data[23:0];
				REG_POWER_LOW: power_low_q <= cfg_data[23:0];
				REG_POWER_HIGH: power_high_q <= cfg_data[23:0];
				REG_PEAK_MEAN: peak_mean_q <= cfg_data[31:0];
				REG_PEAK_WIDTH: peak_width_q <= cfg_data[30:0];
				REG_NORM_SCALE: norm_scale_q <= cfg_data;
				default: ;
			endcase
		end
	end

	logic en;
	logic [LATENCY-1:0] vld_q;

	assign en = !vld_q[LATENCY-1] || out_ready;
	assign in_ready = en;
	assign out_valid = vld_q[LATENCY-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LATENCY-2:0], in_valid};
		end
	end

	// difference and magnitude
	logic [32:0] diff;
	logic [32:0] ad;
	logic [30:0] sig;
	div_t div_a_s1;

	always_comb begin
		diff = {x_position[31], x_position} - {peak_mean_q[31], peak_mean_q};
		ad = diff[32] ? 33'd0 - diff : diff;
		sig = (peak_width_q == 31'd0) ? 31'd1 : peak_width_q;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			div_a_s1.num <= {ad, 16'd0};
			div_a_s1.quo <= '0;
			div_a_s1.rem <= '0;
			div_a_s1.neg <= diff[32];
		end
	end

	div_t div_c [0:DIV_BITS];
	assign div_c[0] = div_a_s1;

	for (genvar g = 0; g < DIV_BITS; g++) begin : g_div
		dscb_div_cell u_cell (
			.clk(clk),
			.en(en),
			.divisor(sig),
			.d_in(div_c[g]),
			.d_out(div_c[g+1])
		);
	end

	// region select and tail terms
	logic [DIV_BITS-1:0] tm;
	logic neg;
	logic [23:0] a_sel, n_sel;
	logic [DIV_BITS-1:0] dd;
	logic [1:0] c_region_s1, c_region_s2;
	logic [23:0] c_a_s1, c_n_s1, c_n_s2;
	logic [38:0] c_d_s1;
	logic [31:0] c_tm_s1;
	logic c_big_s1, c_big_s2;
	logic [63:0] c_sq_s2;
	logic [43:0] c_adlo_s2;
	logic [42:0] c_adhi_s2;
	logic [47:0] c_aa_s2;
	logic [63:0] c_num_s3, c_den_s3;
	side_t c_side_s3;
	logic [62:0] sq_half;

	always_comb begin
		tm = div_c[DIV_BITS].quo;
		neg = div_c[DIV_BITS].neg;
		a_sel = neg ? alpha_low_q : alpha_high_q;
		n_sel = neg ? power_low_q : power_high_q;
		if (n_sel == 24'd0) begin
			n_sel = 24'd1;
		end
		dd = tm - DIV_BITS'(a_sel);
		sq_half = c_sq_s2[63:1];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (neg && tm > DIV_BITS'(alpha_low_q)) begin
				c_region_s1 <= REGION_LOW;
			end else if (!neg && tm > DIV_BITS'(alpha_high_q)) begin
				c_region_s1 <= REGION_HIGH;
			end else begin
				c_region_s1 <= REGION_CORE;
			end
			c_a_s1 <= a_sel;
			c_n_s1 <= n_sel;
			c_d_s1 <= (dd > DIV_BITS'(D_CAP)) ? D_CAP : dd[38:0];
			c_tm_s1 <= tm[31:0];
			c_big_s1 <= tm[DIV_BITS-1:32] != '0;

			c_sq_s2 <= 64'(c_tm_s1) * 64'(c_tm_s1);
			c_big_s2 <= c_big_s1;
			c_adlo_s2 <= 44'(c_a_s1) * 44'(c_d_s1[19:0]);
			c_adhi_s2 <= 43'(c_a_s1) * 43'(c_d_s1[38:20]);
			c_aa_s2 <= 48'(c_a_s1) * 48'(c_a_s1);
			c_n_s2 <= c_n_s1;
			c_region_s2 <= c_region_s1;

			c_num_s3 <= {24'd0, c_n_s2, 16'd0} + 64'(c_adlo_s2) + {1'b0, c_adhi_s2, 20'd0};
			c_den_s3 <= {24'd0, c_n_s2, 16'd0};
			c_side_s3.region <= c_region_s2;
			c_side_s3.n <= c_n_s2;
			c_side_s3.aa_half <= c_aa_s2[47:1];
			c_side_s3.e_core <= (c_big_s2 || sq_half > E_CAP) ? E_CAP : sq_half;
			c_side_s3.p_num <= '0;
			c_side_s3.p_den <= '0;
		end
	end

	// leading one and mantissa
	function automatic logic [2:0] top_byte(input logic [63:0] v);
		logic [2:0] gi;
		gi = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (v[8*i +: 8] != 8'd0) begin
				gi = 3'(i);
			end
		end
		return gi;
	endfunction

	function automatic logic [2:0] top_bit(input logic [7:0] b);
		logic [2:0] bi;
		bi = 3'd0;
		for (int i = 0; i < 8; i++) begin
			if (b[i]) begin
				bi = 3'(i);
			end
		end
		return bi;
	endfunction

	function automatic logic [31:0] norm_m(input logic [63:0] v, input logic [5:0] p);
		logic [63:0] s;
		if (p >= 6'd31) begin
			s = v >> (p - 6'd31);
		end else begin
			s = v << (6'd31 - p);
		end
		return s[31:0];
	endfunction

	logic [63:0] d_num_s1, d_den_s1;
	logic [2:0] d_gn_s1, d_gd_s1;
	side_t d_side_s1, d_side_s2;
	side_t d_side_m;
	logic [5:0] pn, pd;
	logic [31:0] d_mn_s2, d_md_s2;

	always_comb begin
		pn = {d_gn_s1, top_bit(d_num_s1[8*d_gn_s1 +: 8])};
		pd = {d_gd_s1, top_bit(d_den_s1[8*d_gd_s1 +: 8])};
		d_side_m = d_side_s1;
		d_side_m.p_num = pn;
		d_side_m.p_den = pd;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_num_s1 <= c_num_s3;
			d_den_s1 <= c_den_s3;
			d_gn_s1 <= top_byte(c_num_s3);
			d_gd_s1 <= top_byte(c_den_s3);
			d_side_s1 <= c_side_s3;

			d_mn_s2 <= norm_m(d_num_s1, pn);
			d_md_s2 <= norm_m(d_den_s1, pd);
			d_side_s2 <= d_side_m;
		end
	end

	logic [31:0] ln_m [0:EXP_ITER];
	logic [31:0] ld_m [0:EXP_ITER];
	logic [EXP_ITER-1:0] ln_f [0:EXP_ITER];
	logic [EXP_ITER-1:0] ld_f [0:EXP_ITER];
	side_t side_l [0:EXP_ITER];

	assign ln_m[0] = d_mn_s2;
	assign ld_m[0] = d_md_s2;
	assign ln_f[0] = '0;
	assign ld_f[0] = '0;
	assign side_l[0] = d_side_s2;

	for (genvar g = 0; g < EXP_ITER; g++) begin : g_log
		dscb_log_cell u_num (
			.clk(clk),
			.en(en),
			.m_in(ln_m[g]),
			.frac_in(ln_f[g]),
			.m_out(ln_m[g+1]),
			.frac_out(ln_f[g+1])
		);
		dscb_log_cell u_den (
			.clk(clk),
			.en(en),
			.m_in(ld_m[g]),
			.frac_in(ld_f[g]),
			.m_out(ld_m[g+1]),
			.frac_out(ld_f[g+1])
		);
		always_ff @(posedge clk) begin
			if (en) begin
				side_l[g+1] <= side_l[g];
			end
		end
	end

	// tail exponent, or the core exponent in the core region
	side_t sl;
	logic [45:0] lnum, lden;
	logic [45:0] e_lg_s1;
	side_t e_side_s1, e_side_s2, e_side_s3, e_side_s4;
	logic [63:0] e_plo_s2;
	logic [45:0] e_phi_s2;
	logic [77:0] tot;
	logic [37:0] e_ln_s3;
	logic [55:0] e_nlo_s4;
	logic [29:0] e_nhi_s4;
	logic [62:0] nsum;
	logic [47:0] e_tail;
	logic [62:0] e_e_s5;
	logic [1:0] e_region_s5;

	always_comb begin
		sl = side_l[EXP_ITER];
		lnum = {sl.p_num, 40'd0} | (46'(ln_f[EXP_ITER]) << (40 - EXP_ITER));
		lden = {sl.p_den, 40'd0} | (46'(ld_f[EXP_ITER]) << (40 - EXP_ITER));
		tot = 78'(e_plo_s2) + {e_phi_s2, 32'd0};
		nsum = 63'(e_nlo_s4) + {1'b0, e_nhi_s4, 32'd0};
		e_tail = 48'(e_side_s4.aa_half) + 48'(nsum[62:16]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			e_lg_s1 <= (lnum > lden) ? lnum - lden : 46'd0;
			e_side_s1 <= sl;

			e_plo_s2 <= 64'(e_lg_s1[31:0]) * 64'(LN2_Q32);
			e_phi_s2 <= 46'(e_lg_s1[45:32]) * 46'(LN2_Q32);
			e_side_s2 <= e_side_s1;

			e_ln_s3 <= tot[77:40];
			e_side_s3 <= e_side_s2;

			e_nlo_s4 <= 56'(e_side_s3.n) * 56'(e_ln_s3[31:0]);
			e_nhi_s4 <= 30'(e_side_s3.n) * 30'(e_ln_s3[37:32]);
			e_side_s4 <= e_side_s3;

			e_e_s5 <= (e_side_s4.region == REGION_CORE) ? e_side_s4.e_core : 63'(e_tail);
			e_region_s5 <= e_side_s4.region;
		end
	end

	// split exponent into multiples of ln 2 and a remainder
	logic [36:0] f_rem [0:6];
	exps_t f_side [0:6];

	always_ff @(posedge clk) begin
		if (en) begin
			f_rem[0] <= e_e_s5[36:0];
			f_side[0].region <= e_region_s5;
			f_side[0].zero <= e_e_s5 >= 63'(K_LIMIT);
			f_side[0].k <= '0;
		end
	end

	for (genvar j = 0; j < 6; j++) begin : g_kdiv
		localparam int Shift = 5 - j;
		localparam logic [36:0] Sub = 37'(LN2_Q32) << Shift;
		always_ff @(posedge clk) begin
			if (en) begin
				f_side[j+1].region <= f_side[j].region;
				f_side[j+1].zero <= f_side[j].zero;
				if (f_rem[j] >= Sub) begin
					f_rem[j+1] <= f_rem[j] - Sub;
					f_side[j+1].k <= f_side[j].k | (6'd1 << Shift);
				end else begin
					f_rem[j+1] <= f_rem[j];
					f_side[j+1].k <= f_side[j].k;
				end
			end
		end
	end

	logic [32:0] g_p [0:EXP_ITER];
	logic [31:0] g_r [0:EXP_ITER];
	exps_t g_side [0:3*EXP_ITER];

	assign g_p[0] = ONE_Q32;
	assign g_r[0] = f_rem[6][31:0];
	assign g_side[0] = f_side[6];

	for (genvar g = 0; g < EXP_ITER; g++) begin : g_exp
		dscb_exp_cell u_cell (
			.clk(clk),
			.en(en),
			.idx(IDX_W'(EXP_ITER - g)),
			.p_in(g_p[g]),
			.r_in(g_r[g]),
			.p_out(g_p[g+1]),
			.r_out(g_r[g+1])
		);
	end

	for (genvar s = 0; s < 3 * EXP_ITER; s++) begin : g_eside
		always_ff @(posedge clk) begin
			if (en) begin
				g_side[s+1] <= g_side[s];
			end
		end
	end

	// scale by norm
	exps_t gs;
	logic [32:0] y;
	logic [31:0] h_y_s1;
	logic h_one_s1, h_one_s2;
	logic [1:0] h_region_s1, h_region_s2, h_region_s3;
	logic [63:0] h_lo_s2;
	logic [47:0] h_hi_s2;
	logic [79:0] hsum;
	logic [47:0] h_shape_s3;

	always_comb begin
		gs = g_side[3*EXP_ITER];
		y = gs.zero ? 33'd0 : (g_p[EXP_ITER] >> gs.k);
		hsum = 80'(h_lo_s2) + {h_hi_s2, 32'd0};
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_y_s1 <= y[31:0];
			h_one_s1 <= y[32];
			h_region_s1 <= gs.region;

			h_lo_s2 <= 64'(norm_scale_q[31:0]) * 64'(h_y_s1);
			h_hi_s2 <= 48'(norm_scale_q[47:32]) * 48'(h_y_s1);
			h_one_s2 <= h_one_s1;
			h_region_s2 <= h_region_s1;

			h_shape_s3 <= h_one_s2 ? norm_scale_q : hsum[79:32];
			h_region_s3 <= h_region_s2;
		end
	end

	assign shape_value = h_shape_s3;
	assign region = h_region_s3;

	a_shape_le_norm: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> shape_value <= norm_scale_q)
		else $error("shape above norm");

	a_stall_only: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (out_valid && !out_ready))
		else $error("input stalled without output stall");

	a_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && !vld_q[LATENCY-2]) |=> !out_valid)
		else $error("result repeated");

endmodule

FILE: dv/tb.sv
`timescale 1ns / 100ps

module tb;
	import dscb_pkg::*;

	localparam logic [2:0] REG_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT = 1_000_000;
	localparam int HOLD_CYCLES = 400;

	logic clk, arst_n;
	logic cfg_we;
	logic [2:0] cfg_index;
	logic [47:0] cfg_data;
	logic in_valid, in_ready;
	logic signed [31:0] x_position;
	logic out_valid, out_ready;
	logic [47:0] shape_value;
	logic [1:0] region;

	double_sided_crystal_ball_eval dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .x_position(x_position),
		.out_valid(out_valid), .out_ready(out_ready),
		.shape_value(shape_value), .region(region)
	);

	typedef struct {
		logic [47:0] value;
		logic [1:0] reg_id;
	} shape_t;

	logic [23:0] alpha_lo, alpha_hi, pow_lo, pow_hi;
	logic [31:0] mean_r;
	logic [30:0] width_r;
	logic [47:0] norm_r;

	logic [31:0] corner_x [16] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
		32'h8000_0000, 32'h0001_0000, 32'hFFFF_0000, 32'hFFFE_FFFF,
		32'h0002_0000, 32'h0002_0001, 32'h0003_0000, 32'hFFFB_0000,
		32'h0100_0000, 32'hFF00_0000, 32'h5555_5555, 32'hAAAA_AAAA};

	logic [31:0] x_queue[$];
	shape_t shape_queue[$];
	int errors = 0;
	int cycles = 0;
	int hold = 0;
	bit hold_go = 0;
	bit quiet = 0;

	function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
		logic [127:0] prod;
		prod = ({64'd0, a} * {64'd0, b}) >> s;
		return (prod > {65'd0, E_CAP}) ? 64'(E_CAP) : prod[63:0];
	endfunction

	function automatic logic [63:0] log2_fix(logic [63:0] v);
		int p;
		logic [63:0] m, r;
		p = 63;
		while (p > 0 && !v[p])
			p--;
		m = (p >= 31) ? (v >> (p - 31)) : (v << (31 - p));
		r = 64'(p) << 40;
		for (int i = 1; i <= EXP_ITER && i <= 40; i++) begin
			m = (m * m) >> 31;
			if (m >> 32) begin
				r[40 - i] = 1'b1;
				m = m >> 1;
			end
		end
		return r;
	endfunction

	function automatic logic [63:0] exp_decay(logic [63:0] e);
		logic [63:0] k, r, p;
		k = e / 64'(LN2_Q32);
		r = e % 64'(LN2_Q32);
		p = 64'(ONE_Q32);
		if (k > 32)
			return 0;
		for (int i = EXP_ITER; i >= 1; i--)
			p = 64'(ONE_Q32) - ((r * p) >> 32) / 64'(i);
		return p >> k;
	endfunction

	function automatic logic [63:0] tail_energy(logic [63:0] a, logic [63:0] n,
			logic [63:0] tm);
		logic [63:0] d, den, num, l1, l2, lg;
		d = tm - a;
		if (d > 64'(D_CAP))
			d = 64'(D_CAP);
		if (n == 0)
			n = 1;
		den = n << 16;
		num = den + a * d;
		l1 = log2_fix(num);
		l2 = log2_fix(den);
		lg = (l1 > l2) ? l1 - l2 : 0;
		lg = mul_shift(lg, 64'(LN2_Q32), 40);
		return ((a * a) >> 1) + mul_shift(n, lg, 16);
	endfunction

	function automatic shape_t predict_shape(logic [31:0] x);
		shape_t res;
		longint diff;
		logic [63:0] ad, sig, tm, e, y;
		bit neg;
		diff = longint'($signed(x)) - longint'($signed(mean_r));
		neg = diff < 0;
		ad = neg ? 64'(-diff) : 64'(diff);
		sig = (width_r != 0) ? 64'(width_r) : 64'd1;
		tm = (ad << 16) / sig;
		if (neg && tm > alpha_lo) begin
			res.reg_id = REGION_LOW;
			e = tail_energy(64'(alpha_lo), 64'(pow_lo), tm);
		end else if (!neg && tm > alpha_hi) begin
			res.reg_id = REGION_HIGH;
			e = tail_energy(64'(alpha_hi), 64'(pow_hi), tm);
		end else begin
			res.reg_id = REGION_CORE;
			e = mul_shift(tm, tm, 1);
		end
		if (e > 64'(E_CAP))
			e = 64'(E_CAP);
		y = exp_decay(e);
		res.value = (y >= 64'(ONE_Q32)) ? norm_r : 48'(mul_shift(64'(norm_r), y, 32));
		return res;
	endfunction

	task automatic report(string what, logic [63:0] got, logic [63:0] want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		errors++;
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (hold_go && hold < HOLD_CYCLES)
			hold <= hold + 1;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 0;
			x_position <= 0;
		end else begin
			if (in_valid && in_ready)
				shape_queue.push_back(predict_shape(x_position));
			if (!in_valid || in_ready) begin
				if (x_queue.size() > 0 && (quiet || $urandom_range(99) >= 13)) begin
					in_valid <= 1;
					x_position <= x_queue.pop_front();
				end else begin
					in_valid <= 0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		shape_t want;
		if (!arst_n) begin
			out_ready <= 0;
		end else begin
			if (out_valid && out_ready) begin
				if (shape_queue.size() == 0) begin
					report("unexpected result", 64'(shape_value), 64'd0);
				end else begin
					want = shape_queue.pop_front();
					if (shape_value !== want.value)
						report("shape_value", 64'(shape_value), 64'(want.value));
					if (region !== want.reg_id)
						report("region", 64'(region), 64'(want.reg_id));
				end
			end
			if (hold_go && hold < HOLD_CYCLES) begin
				out_ready <= 0;
			end else begin
				out_ready <= quiet || $urandom_range(99) >= 13;
			end
		end
	end

	task automatic write_reg(logic [2:0] idx, logic [47:0] v);
		@(posedge clk);
		cfg_we <= 1;
		cfg_index <= idx;
		cfg_data <= v;
		case (idx)
			REG_ALPHA_LOW: alpha_lo = v[23:0];
			REG_ALPHA_HIGH: alpha_hi = v[23:0];
			REG_POWER_LOW: pow_lo = v[23:0];
			REG_POWER_HIGH: pow_hi = v[23:0];
			REG_PEAK_MEAN: mean_r = v[31:0];
			REG_PEAK_WIDTH: width_r = v[30:0];
			REG_NORM_SCALE: norm_r = v;
			default: ;
		endcase
	endtask

	task automatic end_writes();
		@(posedge clk);
		cfg_we <= 0;
	endtask

	task automatic drain();
		while (x_queue.size() > 0 || in_valid || shape_queue.size() > 0)
			@(posedge clk);
	endtask

	function automatic logic [31:0] pick_x();
		int t;
		longint sig;
		if ($urandom_range(9) < 3)
			return $urandom;
		sig = (width_r != 0) ? longint'(width_r) : 1;
		t = int'($urandom_range(20 * 65536)) - 10 * 65536;
		return 32'(longint'($signed(mean_r)) + ((sig * t) >>> 16));
	endfunction

	task automatic push_random(int count);
		repeat (count)
			x_queue.push_back(pick_x());
	endtask

	function automatic logic [47:0] junk_hi(int keep, logic [47:0] v);
		logic [47:0] mask;
		mask = (48'd1 << keep) - 48'd1;
		return (v & mask) | (48'({$urandom, $urandom}) & ~mask);
	endfunction

	task automatic random_config();
		write_reg(REG_ALPHA_LOW, junk_hi(24, 48'($urandom_range(5 * 65536))));
		write_reg(REG_ALPHA_HIGH, junk_hi(24, 48'($urandom_range(5 * 65536))));
		write_reg(REG_POWER_LOW, junk_hi(24, 48'($urandom_range(8 * 65536))));
		write_reg(REG_POWER_HIGH, junk_hi(24, 48'($urandom_range(8 * 65536))));
		write_reg(REG_PEAK_MEAN, junk_hi(32, 48'($urandom)));
		write_reg(REG_PEAK_WIDTH, junk_hi(31, 48'($urandom_range(1 << 24, 1 << 10))));
		write_reg(REG_NORM_SCALE, 48'({$urandom, $urandom}));
		end_writes();
	endtask

	initial begin
		cfg_we = 0;
		cfg_index = 0;
		cfg_data = 0;
		alpha_lo = 24'd65536;
		alpha_hi = 24'd131072;
		pow_lo = 24'd131072;
		pow_hi = 24'd65536;
		mean_r = 0;
		width_r = 31'd65536;
		norm_r = 48'd65536;
		arst_n = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1;

		foreach (corner_x[i])
			x_queue.push_back(corner_x[i]);
		drain();

		write_reg(REG_ALPHA_LOW, 48'hFFFF_FFFF_FFFF);
		write_reg(REG_ALPHA_HIGH, 48'hFF_FFFF);
		write_reg(REG_POWER_LOW, 48'hFF_FFFF);
		write_reg(REG_POWER_HIGH, 48'hFFFF_FFFF_FFFF);
		write_reg(REG_PEAK_MEAN, 48'h7FFF_FFFF);
		write_reg(REG_PEAK_WIDTH, 48'hFFFF_FFFF_FFFF);
		write_reg(REG_NORM_SCALE, 48'hFFFF_FFFF_FFFF);
		write_reg(REG_UNUSED, 48'h0);
		end_writes();
		x_queue.push_back(32'h8000_0000);
		x_queue.push_back(32'h7FFF_FFFF);
		push_random(40);
		drain();

		write_reg(REG_ALPHA_LOW, 48'h0);
		write_reg(REG_ALPHA_HIGH, 48'h0);
		write_reg(REG_POWER_LOW, 48'h0);
		write_reg(REG_POWER_HIGH, 48'h0);
		write_reg(REG_PEAK_MEAN, 48'h8000_0000);
		write_reg(REG_PEAK_WIDTH, 48'h0);
		write_reg(REG_UNUSED, 48'hFFFF_FFFF_FFFF);
		end_writes();
		x_queue.push_back(32'h8000_0000);
		x_queue.push_back(32'h8000_0001);
		x_queue.push_back(32'h7FFF_FFFF);
		push_random(40);
		drain();

		write_reg(REG_PEAK_MEAN, 48'h7FFF_FFFF);
		write_reg(REG_PEAK_WIDTH, 48'h1);
		write_reg(REG_ALPHA_LOW, 48'h1);
		write_reg(REG_ALPHA_HIGH, 48'h1);
		write_reg(REG_POWER_LOW, 48'h1);
		write_reg(REG_POWER_HIGH, 48'h1);
		write_reg(REG_NORM_SCALE, 48'h0);
		end_writes();
		x_queue.push_back(32'h8000_0000);
		push_random(30);
		drain();

		for (int ph = 0; ph < 10; ph++) begin
			random_config();
			quiet = (ph == 3);
			if (ph == 6)
				hold_go = 1;
			push_random(150);
			drain();
		end
		quiet = 0;

		repeat (LATENCY + 20) @(posedge clk);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
